@@ rtl/core/srr_pkg.sv @@
// Package for the selective-repeat reorder receiver.
// Holds sizes, result and disposition codes, and the request to the modulo unit.
// No dependencies.
package srr_pkg;

	localparam int WINDOW_SLOTS = 8;
	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
	localparam int SEQ_W = 16;
	localparam int LEN_W = 11;
	localparam int SUM_W = SEQ_W + 1;

	localparam logic [1:0] KIND_SYNACK = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_FIN = 2'd2;

	localparam logic [1:0] OK_DELIVER = 2'd0;
	localparam logic [1:0] OK_ACK = 2'd1;
	localparam logic [1:0] OK_FINACK = 2'd2;

	localparam logic [2:0] DISP_INORDER = 3'd0;
	localparam logic [2:0] DISP_BUFFERED = 3'd1;
	localparam logic [2:0] DISP_DUP = 3'd2;
	localparam logic [2:0] DISP_FULL = 3'd3;
	localparam logic [2:0] DISP_CONTROL = 3'd4;

	localparam logic [2:0] ADDR_SEQ_MODULUS = 3'd0;
	localparam logic [SEQ_W-1:0] MODULUS_RESET = 16'd30720;

	typedef struct packed {
		logic go;
		logic [SUM_W-1:0] dividend;
	} srr_mod_req_t;

endpackage

@@ rtl/core/srr_mod.sv @@
// Bit-serial restoring remainder unit: dividend modulo the sequence modulus.
// Takes one dividend bit per cycle. Depends on srr_pkg.
module srr_mod
	import srr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  srr_mod_req_t req,
	input  logic [SEQ_W-1:0] modulus,
	output logic done,
	output logic [SEQ_W-1:0] rem
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] div_q;
	logic [SUM_W-1:0] rem_q;
	logic [STEP_W-1:0] steps_q;
	logic run_q;
	logic done_q;
	logic [SUM_W-1:0] m_full;
	logic [SUM_W:0] trial;

	// A modulus of zero stands for the full 16-bit space.
	assign m_full = (modulus == '0) ? {1'b1, {SEQ_W{1'b0}}} : {1'b0, modulus};
	assign trial = {rem_q, div_q[SUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				steps_q <= STEP_W'(SUM_W);
			end else if (run_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == STEP_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			div_q <= req.dividend;
			rem_q <= '0;
		end else if (run_q) begin
			div_q <= {div_q[SUM_W-2:0], 1'b0};
			if (trial >= {1'b0, m_full}) begin
				rem_q <= SUM_W'(trial - {1'b0, m_full});
			end else begin
				rem_q <= trial[SUM_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem = rem_q[SEQ_W-1:0];

endmodule

@@ rtl/core/selective_repeat_reorder_receiver.sv @@
// Top level of the selective-repeat reorder receiver: sequencer, hold buffer,
// recent ring and APB register. Depends on srr_pkg and srr_mod.
//
// channel   signals                                   handshake
// request   kind pkt_seq pkt_ack payload_len          start high, busy low
// result    out_kind deliver_seq deliver_len          result_valid, one cycle
//           reply_seq reply_ack disposition last
// config    psel penable pwrite paddr pwdata prdata   APB, pready always high
//
// A SYN-ACK or FIN is accepted, runs through the bit-serial modulo unit, and then
// updates state and presents the reply. An in-order packet is delivered on
// acceptance and passes through the modulo unit; each held packet that a scan of the
// hold buffer then finds next in order does the same, and a final scan finding none
// ends with the acknowledgement; an out-of-order packet is answered on acceptance.
// Reset clears the expectation, valid bits and ring counters; no clearing pass.
// Results leave as one-cycle strobes and are never held off.
module selective_repeat_reorder_receiver
	import srr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] kind,
	input  logic [SEQ_W-1:0] pkt_seq,
	input  logic [SEQ_W-1:0] pkt_ack,
	input  logic [LEN_W-1:0] payload_len,
	output logic result_valid,
	output logic [1:0] out_kind,
	output logic [SEQ_W-1:0] deliver_seq,
	output logic [LEN_W-1:0] deliver_len,
	output logic [SEQ_W-1:0] reply_seq,
	output logic [SEQ_W-1:0] reply_ack,
	output logic [2:0] disposition,
	output logic last,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN
	} state_t;

	state_t state_q;
	logic [SEQ_W-1:0] modulus_q;
	logic [SEQ_W-1:0] expected_q;
	logic [1:0] kind_q;
	logic [SEQ_W-1:0] ack_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SEQ_W-1:0] held_seq_q [WINDOW_SLOTS];
	logic [LEN_W-1:0] held_len_q [WINDOW_SLOTS];
	logic [WINDOW_SLOTS-1:0] held_valid_q;
	logic [SEQ_W-1:0] recent_seq_q [WINDOW_SLOTS];
	logic [CNT_W-1:0] recent_count_q;
	logic [SLOT_W-1:0] recent_head_q;

	logic res_valid_q;
	logic [1:0] res_kind_q;
	logic [SEQ_W-1:0] res_dseq_q;
	logic [LEN_W-1:0] res_dlen_q;
	logic [SEQ_W-1:0] res_rseq_q;
	logic [SEQ_W-1:0] res_rack_q;
	logic [2:0] res_disp_q;
	logic res_last_q;

	srr_mod_req_t mod_req;
	logic mod_done;
	logic [SEQ_W-1:0] mod_rem;

	logic dup_hit;
	logic free_any;
	logic [SLOT_W-1:0] free_idx;
	logic scan_hit;
	logic accept;
	logic push_en;
	logic [SEQ_W-1:0] push_seq;

	srr_mod u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.req(mod_req),
		.modulus(modulus_q),
		.done(mod_done),
		.rem(mod_rem)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign scan_hit = held_valid_q[idx_q] && (held_seq_q[idx_q] == expected_q);

	// Duplicate check over the hold buffer and the written part of the ring; also finds the lowest free hold slot.
	always_comb begin
		dup_hit = 1'b0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
			if (held_valid_q[i]) begin
				if (held_seq_q[i] == pkt_seq) dup_hit = 1'b1;
			end else begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
			if ((CNT_W'(i) < recent_count_q) && (recent_seq_q[i] == pkt_seq)) begin
				dup_hit = 1'b1;
			end
		end
	end

	always_comb begin
		mod_req.go = 1'b0;
		mod_req.dividend = '0;
		push_en = 1'b0;
		push_seq = pkt_seq;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_SYNACK || kind == KIND_FIN) begin
						mod_req.go = 1'b1;
						mod_req.dividend = SUM_W'(pkt_seq) + SUM_W'(1);
						push_en = (kind == KIND_SYNACK);
					end else if (kind == KIND_DATA && pkt_seq == expected_q) begin
						mod_req.go = 1'b1;
						mod_req.dividend = SUM_W'(expected_q) + SUM_W'(payload_len);
						push_en = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					mod_req.go = 1'b1;
					mod_req.dividend = SUM_W'(expected_q) + SUM_W'(held_len_q[idx_q]);
					push_en = 1'b1;
					push_seq = held_seq_q[idx_q];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			modulus_q <= MODULUS_RESET;
			expected_q <= '0;
			held_valid_q <= '0;
			recent_count_q <= '0;
			recent_head_q <= '0;
			res_valid_q <= 1'b0;
			res_kind_q <= OK_DELIVER;
			res_dseq_q <= '0;
			res_dlen_q <= '0;
			res_rseq_q <= '0;
			res_rack_q <= '0;
			res_disp_q <= DISP_INORDER;
			res_last_q <= 1'b0;
			idx_q <= '0;
			kind_q <= KIND_SYNACK;
		end else begin
			res_valid_q <= 1'b0;
			if (psel && penable && pwrite && paddr == ADDR_SEQ_MODULUS) begin
				modulus_q <= pwdata[SEQ_W-1:0];
			end
			if (push_en) begin
				recent_head_q <= (recent_head_q == SLOT_W'(WINDOW_SLOTS - 1))
					? '0 : recent_head_q + 1'b1;
				if (recent_count_q != CNT_W'(WINDOW_SLOTS)) begin
					recent_count_q <= recent_count_q + 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q <= kind;
						if (kind == KIND_SYNACK || kind == KIND_FIN) begin
							state_q <= ST_MOD;
						end else if (kind == KIND_DATA) begin
							if (pkt_seq == expected_q) begin
								res_valid_q <= 1'b1;
								res_kind_q <= OK_DELIVER;
								res_dseq_q <= pkt_seq;
								res_dlen_q <= payload_len;
								res_rseq_q <= '0;
								res_rack_q <= '0;
								res_disp_q <= DISP_INORDER;
								res_last_q <= 1'b0;
								state_q <= ST_MOD;
							end else begin
								res_valid_q <= 1'b1;
								res_kind_q <= OK_ACK;
								res_dseq_q <= '0;
								res_dlen_q <= '0;
								res_rseq_q <= pkt_ack;
								res_rack_q <= expected_q;
								res_last_q <= 1'b1;
								if (dup_hit) begin
									res_disp_q <= DISP_DUP;
								end else if (!free_any) begin
									res_disp_q <= DISP_FULL;
								end else begin
									res_disp_q <= DISP_BUFFERED;
									held_valid_q[free_idx] <= 1'b1;
								end
							end
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						if (kind_q == KIND_DATA) begin
							expected_q <= mod_rem;
							idx_q <= '0;
							state_q <= ST_SCAN;
						end else begin
							if (kind_q == KIND_SYNACK) expected_q <= mod_rem;
							res_valid_q <= 1'b1;
							res_kind_q <= (kind_q == KIND_SYNACK) ? OK_ACK : OK_FINACK;
							res_dseq_q <= '0;
							res_dlen_q <= '0;
							res_rseq_q <= ack_q;
							res_rack_q <= mod_rem;
							res_disp_q <= DISP_CONTROL;
							res_last_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						res_valid_q <= 1'b1;
						res_kind_q <= OK_DELIVER;
						res_dseq_q <= held_seq_q[idx_q];
						res_dlen_q <= held_len_q[idx_q];
						res_rseq_q <= '0;
						res_rack_q <= '0;
						res_disp_q <= DISP_INORDER;
						res_last_q <= 1'b0;
						held_valid_q[idx_q] <= 1'b0;
						state_q <= ST_MOD;
					end else if (idx_q == SLOT_W'(WINDOW_SLOTS - 1)) begin
						res_valid_q <= 1'b1;
						res_kind_q <= OK_ACK;
						res_dseq_q <= '0;
						res_dlen_q <= '0;
						res_rseq_q <= ack_q;
						res_rack_q <= expected_q;
						res_disp_q <= DISP_INORDER;
						res_last_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload storage carries no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			ack_q <= pkt_ack;
			if (kind == KIND_DATA && pkt_seq != expected_q && !dup_hit && free_any) begin
				held_seq_q[free_idx] <= pkt_seq;
				held_len_q[free_idx] <= payload_len;
			end
		end
		if (push_en) begin
			recent_seq_q[recent_head_q] <= push_seq;
		end
	end

	assign prdata = (paddr == ADDR_SEQ_MODULUS) ? {16'd0, modulus_q} : 32'd0;
	assign pready = 1'b1;

	assign result_valid = res_valid_q;
	assign out_kind = res_kind_q;
	assign deliver_seq = res_dseq_q;
	assign deliver_len = res_dlen_q;
	assign reply_seq = res_rseq_q;
	assign reply_ack = res_rack_q;
	assign disposition = res_disp_q;
	assign last = res_last_q;

endmodule

@@ verif/srr_checker.sv @@
// Checker for the selective-repeat reorder receiver: predicts the results of
// each accepted request and compares them with the strobed results.
// Depends on srr_pkg.
`timescale 1ns / 1ps
module srr_checker
	import srr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic [1:0] kind,
	input  logic [SEQ_W-1:0] pkt_seq,
	input  logic [SEQ_W-1:0] pkt_ack,
	input  logic [LEN_W-1:0] payload_len,
	input  logic result_valid,
	input  logic [1:0] out_kind,
	input  logic [SEQ_W-1:0] deliver_seq,
	input  logic [LEN_W-1:0] deliver_len,
	input  logic [SEQ_W-1:0] reply_seq,
	input  logic [SEQ_W-1:0] reply_ack,
	input  logic [2:0] disposition,
	input  logic last,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic [1:0] okind;
		logic [SEQ_W-1:0] dseq;
		logic [LEN_W-1:0] dlen;
		logic [SEQ_W-1:0] rseq;
		logic [SEQ_W-1:0] rack;
		logic [2:0] disp;
		logic lst;
	} rx_result_t;

	rx_result_t expected_results[$];
	logic [SEQ_W-1:0] modulus;
	logic [SEQ_W-1:0] next_seq;
	logic [SEQ_W-1:0] hold_seq [WINDOW_SLOTS];
	logic [LEN_W-1:0] hold_len [WINDOW_SLOTS];
	logic hold_ok [WINDOW_SLOTS];
	logic [SEQ_W-1:0] seen_seq [WINDOW_SLOTS];
	int seen_count;
	int seen_head;

	assign pending = expected_results.size();

	function automatic logic [SEQ_W-1:0] seq_add(logic [SEQ_W-1:0] a, logic [LEN_W-1:0] b);
		int unsigned m;
		m = (modulus == 0) ? 65536 : modulus;
		return SEQ_W'((int'(a) + int'(b)) % m);
	endfunction

	function automatic void note_delivered(logic [SEQ_W-1:0] s);
		seen_seq[seen_head] = s;
		seen_head = (seen_head + 1) % WINDOW_SLOTS;
		if (seen_count < WINDOW_SLOTS)
			seen_count++;
	endfunction

	function automatic void add_expected(logic [1:0] k, logic [SEQ_W-1:0] ds,
			logic [LEN_W-1:0] dl, logic [SEQ_W-1:0] rs, logic [SEQ_W-1:0] ra,
			logic [2:0] dp, logic l);
		rx_result_t r;
		r = '{k, ds, dl, rs, ra, dp, l};
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void predict_packet(logic [1:0] k, logic [SEQ_W-1:0] s,
			logic [SEQ_W-1:0] a, logic [LEN_W-1:0] len);
		logic found, dup;
		int free_slot;
		logic [2:0] dp;
		if (k == KIND_SYNACK) begin
			next_seq = seq_add(s, LEN_W'(1));
			note_delivered(s);
			add_expected(OK_ACK, '0, '0, a, next_seq, DISP_CONTROL, 1'b1);
		end else if (k == KIND_FIN) begin
			add_expected(OK_FINACK, '0, '0, a, seq_add(s, LEN_W'(1)), DISP_CONTROL, 1'b1);
		end else if (k == KIND_DATA) begin
			if (s == next_seq) begin
				add_expected(OK_DELIVER, s, len, '0, '0, DISP_INORDER, 1'b0);
				note_delivered(s);
				next_seq = seq_add(next_seq, len);
				found = 1'b1;
				while (found) begin
					found = 1'b0;
					for (int i = 0; i < WINDOW_SLOTS; i++) begin
						if (!found && hold_ok[i] && hold_seq[i] == next_seq) begin
							add_expected(OK_DELIVER, hold_seq[i], hold_len[i], '0, '0,
								DISP_INORDER, 1'b0);
							note_delivered(hold_seq[i]);
							hold_ok[i] = 1'b0;
							next_seq = seq_add(next_seq, hold_len[i]);
							found = 1'b1;
						end
					end
				end
				dp = DISP_INORDER;
			end else begin
				dup = 1'b0;
				free_slot = -1;
				for (int i = 0; i < WINDOW_SLOTS; i++) begin
					if (hold_ok[i]) begin
						if (hold_seq[i] == s)
							dup = 1'b1;
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				for (int i = 0; i < seen_count; i++)
					if (seen_seq[i] == s)
						dup = 1'b1;
				if (dup) begin
					dp = DISP_DUP;
				end else if (free_slot < 0) begin
					dp = DISP_FULL;
				end else begin
					hold_seq[free_slot] = s;
					hold_len[free_slot] = len;
					hold_ok[free_slot] = 1'b1;
					dp = DISP_BUFFERED;
				end
			end
			add_expected(OK_ACK, '0, '0, a, next_seq, dp, 1'b1);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rx_result_t got, want;
		if (!arst_n) begin
			modulus = MODULUS_RESET;
			next_seq = 0;
			seen_count = 0;
			seen_head = 0;
			errors = 0;
			for (int i = 0; i < WINDOW_SLOTS; i++)
				hold_ok[i] = 1'b0;
			expected_results.delete();
		end else begin
			// Results of earlier requests are checked before a new request is predicted.
			if (result_valid) begin
				got = '{out_kind, deliver_seq, deliver_len, reply_seq, reply_ack,
					disposition, last};
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p, actual %p", want, got);
					end
				end
			end
			if (psel && penable && pwrite && paddr == {ADDR_SEQ_MODULUS[0], 2'b00})
				modulus = pwdata[SEQ_W-1:0];
			if (start && !busy)
				predict_packet(kind, pkt_seq, pkt_ack, payload_len);
		end
	end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the selective-repeat reorder receiver: drives requests and
// register writes, and gives the verdict. Depends on srr_pkg and srr_checker.
`timescale 1ns / 1ps
module tb_top;
	import srr_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic clk, arst_n, start, busy, result_valid, last, psel, penable, pwrite, pready;
	logic [1:0] kind, out_kind;
	logic [SEQ_W-1:0] pkt_seq, pkt_ack, deliver_seq, reply_seq, reply_ack;
	logic [LEN_W-1:0] payload_len, deliver_len;
	logic [2:0] disposition, paddr;
	logic [31:0] pwdata, prdata;
	int errors, pending;
	logic [SEQ_W-1:0] cur_mod, stream_seq;

	selective_repeat_reorder_receiver dut (.*);
	srr_checker chk (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
		repeat (n) @(posedge clk);
	endtask

	// Ends only after a further clock edge once start is dropped, so start never takes two
	// assignments at one edge when requests follow each other.
	task automatic send_packet(logic [1:0] k, logic [SEQ_W-1:0] s, logic [SEQ_W-1:0] a,
			logic [LEN_W-1:0] len);
		kind <= k;
		pkt_seq <= s;
		pkt_ack <= a;
		payload_len <= len;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_modulus(logic [SEQ_W-1:0] m);
		wait_drained();
		psel <= 1'b1;
		paddr <= {ADDR_SEQ_MODULUS[0], 2'b00};
		pwdata <= {16'h0, m};
		pwrite <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_mod = m;
		@(posedge clk);
	endtask

	function automatic logic [SEQ_W-1:0] wrap(logic [SEQ_W-1:0] a, int b);
		int unsigned m;
		m = (cur_mod == 0) ? 65536 : cur_mod;
		return SEQ_W'((int'(a) + b) % m);
	endfunction

	// A burst of up to a window's worth of data: shuffled in-order segments plus noise.
	task automatic send_burst();
		logic [SEQ_W-1:0] segs [8];
		logic [LEN_W-1:0] lens [8];
		int order [8];
		int n, j, t;
		n = $urandom_range(2, 8);
		for (int i = 0; i < n; i++) begin
			lens[i] = ($urandom_range(0, 15) == 0) ? '0 : LEN_W'($urandom_range(1, 64));
			segs[i] = stream_seq;
			stream_seq = wrap(stream_seq, int'(lens[i]));
			order[i] = i;
		end
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < n; i++) begin
			idle_gap();
			case ($urandom_range(0, 11))
				0: send_packet(KIND_DATA, SEQ_W'($urandom), SEQ_W'($urandom),
					LEN_W'($urandom));
				1: send_packet(KIND_FIN, SEQ_W'($urandom), SEQ_W'($urandom),
					LEN_W'($urandom));
				2: send_packet(KIND_UNUSED, SEQ_W'($urandom), SEQ_W'($urandom),
					LEN_W'($urandom));
				3: send_packet(KIND_DATA, segs[order[$urandom_range(0, i)]],
					SEQ_W'($urandom), lens[order[i]]);
				default: ;
			endcase
			send_packet(KIND_DATA, segs[order[i]], SEQ_W'($urandom), lens[order[i]]);
		end
	endtask

	initial begin
		logic [SEQ_W-1:0] m;
		start = 1'b0;
		kind = KIND_SYNACK;
		pkt_seq = '0;
		pkt_ack = '0;
		payload_len = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_mod = MODULUS_RESET;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: control packets, extremes, the unused kind, reordering and a full buffer.
		send_packet(KIND_SYNACK, 16'hFFFF, 16'hFFFF, 11'h7FF);
		send_packet(KIND_FIN, 16'h0000, 16'h0000, 11'd0);
		send_packet(KIND_FIN, 16'hFFFF, 16'hAAAA, 11'h7FF);
		send_packet(KIND_UNUSED, 16'h1234, 16'h5678, 11'd5);
		send_packet(KIND_SYNACK, 16'd99, 16'h5555, 11'd0);
		send_packet(KIND_DATA, 16'd110, 16'd1, 11'd10);
		send_packet(KIND_DATA, 16'd110, 16'd2, 11'd10);
		send_packet(KIND_DATA, 16'd100, 16'd3, 11'd0);
		send_packet(KIND_DATA, 16'd100, 16'd4, 11'd10);
		send_packet(KIND_DATA, 16'd100, 16'd5, 11'd10);
		for (int i = 0; i < 9; i++)
			send_packet(KIND_DATA, SEQ_W'(1000 + i), 16'd6, 11'd1024);
		send_packet(KIND_DATA, 16'd40000, 16'd7, 11'h7FF);
		send_packet(KIND_DATA, 16'd120, 16'd8, 11'd1024);

		write_modulus(16'd0);
		send_packet(KIND_SYNACK, 16'hFFFF, 16'd1, 11'd0);
		send_packet(KIND_DATA, 16'h0000, 16'd2, 11'd3);
		write_modulus(16'd1);
		send_packet(KIND_SYNACK, 16'd7, 16'd1, 11'd0);
		send_packet(KIND_DATA, 16'd0, 16'd2, 11'd9);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: m = 16'd2;
				1: m = 16'hFFFF;
				2: m = MODULUS_RESET;
				3: m = 16'd0;
				default: m = SEQ_W'($urandom_range(100, 65535));
			endcase
			write_modulus(m);
			stream_seq = wrap(SEQ_W'($urandom), 0);
			send_packet(KIND_SYNACK, wrap(stream_seq, -1 + ((cur_mod == 0) ? 65536 : cur_mod)),
				SEQ_W'($urandom), LEN_W'($urandom));
			for (int b = 0; b < 11; b++) begin
				send_burst();
				if (b == 7)
					wait_drained();
			end
		end

		wait_drained();
		if (errors == 0 && pending == 0)
			$display("** selective_repeat_reorder_receiver: PASSED **");
		else
			$display("** selective_repeat_reorder_receiver: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** selective_repeat_reorder_receiver: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/srr_pkg.sv
rtl/core/srr_mod.sv
rtl/core/selective_repeat_reorder_receiver.sv
verif/srr_checker.sv
verif/tb_top.sv
